/* rtl/dvc_pkg.sv */
// Shared types, widths and constants for the dead-time voltage compensator.
// No dependencies; used by every module of the block.
package dvc_pkg;

  localparam int DW      = 16;            // signed Q7.8 data width
  localparam int VW      = 15;            // unsigned Q7.8 bus / threshold width
  localparam int GW      = 16;            // Q0.16 gain width
  localparam int MW      = VW + GW;       // gain * bus magnitude
  localparam int SQ      = 15;            // smooth-sign quotient bits
  localparam int BPC     = 5;             // quotient bits per divider cycle
  localparam int DIV_CYC = SQ / BPC;
  localparam int CNT_W   = $clog2(DIV_CYC + 1);
  localparam int SW      = SQ + 2;        // smooth sign, signed, +-2^15
  localparam int TSW     = SW + 2;        // 3*s - sum, signed
  localparam int TW      = TSW - 1;       // |3*s - sum|
  localparam int PW      = MW + TW;       // m * |t| plus rounding
  localparam int YW      = PW - 31;       // product scaled down by 2^31
  localparam int RW      = 19;            // width of reciprocal of three
  localparam int RECIP_SH = 20;
  localparam int QW      = YW + RW - RECIP_SH;
  localparam int CFG_DW  = 16;
  localparam int CFG_AW  = 3;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int NPH     = 3;

  localparam logic [PW-1:0]        COMP_RND  = PW'(64'd3221225472); // 3 * 2^30
  localparam logic [RW-1:0]        RECIP3    = RW'(349526);         // ceil(2^20 / 3)
  localparam logic [DW-1:0]        RT3_RECIP = DW'(37837);          // Q0.16
  localparam logic signed [SW-1:0] SIGN_ONE  = SW'(32768);

  typedef enum logic [CFG_AW-1:0] {
    REG_MIN_BUS   = 3'd0,
    REG_GAIN_BASE = 3'd1,
    REG_GAIN_MAX  = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_SIGN_INV  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [VW-1:0] min_bus_voltage;
    logic [GW-1:0] gain_base;
    logic [GW-1:0] gain_max;
    logic [VW-1:0] current_threshold;
    logic          sign_invert;
  } cfg_t;

  // per-phase current class: saturated sign, or |i| to be divided by threshold
  typedef struct packed {
    logic          neg;
    logic          sat;
    logic [VW-1:0] mag;
  } phase_cls_t;

  typedef struct packed {
    logic                      bypass;
    logic [MW-1:0]             mag_v;
    logic signed [DW-1:0]      alpha;
    logic signed [DW-1:0]      beta;
    phase_cls_t [NPH-1:0]      ph;
  } item_t;

  typedef struct packed {
    item_t                 item;
    logic [NPH-1:0][SQ-1:0] quot;
  } div_res_t;

endpackage

/* rtl/dvc_front.sv */
// Front end: takes a sample, decides bypass, forms gain*bus and classifies
// each phase current for the smooth sign. Depends on dvc_pkg.
module dvc_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dvc_pkg::VW-1:0]      bus_voltage,
  input  logic signed [dvc_pkg::DW-1:0] current_u,
  input  logic signed [dvc_pkg::DW-1:0] current_v,
  input  logic signed [dvc_pkg::DW-1:0] current_w,
  input  logic signed [dvc_pkg::DW-1:0] alpha_in,
  input  logic signed [dvc_pkg::DW-1:0] beta_in,
  input  dvc_pkg::cfg_t               cfg,
  input  logic                        q_full,
  output logic                        push,
  output dvc_pkg::item_t              item
);
  import dvc_pkg::*;

  logic [GW-1:0]        gain;
  logic signed [DW-1:0] cur [NPH];
  logic [DW-1:0]        absi [NPH];

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign cur[0]   = current_u;
  assign cur[1]   = current_v;
  assign cur[2]   = current_w;

  always_comb begin
    gain = (cfg.gain_base < cfg.gain_max) ? cfg.gain_base : cfg.gain_max;
    item.bypass = (bus_voltage < cfg.min_bus_voltage) || (gain == '0);
    item.mag_v  = MW'(gain) * MW'(bus_voltage);
    item.alpha  = alpha_in;
    item.beta   = beta_in;
    for (int p = 0; p < NPH; p++) begin
      absi[p] = cur[p][DW-1] ? DW'(-cur[p]) : DW'(cur[p]);
      item.ph[p].neg = cur[p][DW-1];
      // zero threshold: hard sign, anything nonzero saturates
      item.ph[p].sat = (cfg.current_threshold == '0) ? (cur[p] != '0)
                     : (absi[p] >= {1'b0, cfg.current_threshold});
      item.ph[p].mag = absi[p][VW-1:0];
    end
  end

endmodule

/* rtl/dvc_queue.sv */
// Short FIFO between the classifying front end and the compute back end.
// Depends on dvc_pkg.
module dvc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dvc_pkg::item_t din,
  input  logic           pop,
  output logic           nonempty,
  output logic           full,
  output dvc_pkg::item_t dout
);
  import dvc_pkg::*;

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign nonempty = (count != '0);
  assign full     = (count == (QAW+1)'(QDEPTH));
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

/* rtl/dvc_sign_div.sv */
// Smooth-sign divider: |i| * 2^15 / threshold for three phases, restoring,
// several quotient bits per cycle. Depends on dvc_pkg.
module dvc_sign_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [dvc_pkg::VW-1:0] threshold,
  input  logic                  q_nonempty,
  input  dvc_pkg::item_t        q_item,
  output logic                  pop,
  input  logic                  take,
  output logic                  res_valid,
  output dvc_pkg::div_res_t     res
);
  import dvc_pkg::*;

  typedef struct packed {
    logic [VW-1:0] rem;
    logic [SQ-1:0] quot;
  } div_st_t;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  item_t            item;
  div_st_t          st      [NPH];
  div_st_t          st_next [NPH];

  function automatic div_st_t div_steps(input div_st_t s, input logic [VW-1:0] th);
    div_st_t      r;
    logic [VW:0]  r2;
    r = s;
    for (int b = 0; b < BPC; b++) begin
      r2 = {r.rem, 1'b0};
      if (r2 >= {1'b0, th}) begin
        r.rem  = VW'(r2 - {1'b0, th});
        r.quot = {r.quot[SQ-2:0], 1'b1};
      end else begin
        r.rem  = r2[VW-1:0];
        r.quot = {r.quot[SQ-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  assign res_valid = busy && (cnt == CNT_W'(DIV_CYC));
  assign pop       = q_nonempty && (!busy || (res_valid && take));

  always_comb begin
    res.item = item;
    for (int p = 0; p < NPH; p++) begin
      st_next[p]  = div_steps(st[p], threshold);
      res.quot[p] = st[p].quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (res_valid && take) begin
      busy <= 1'b0;
    end else if (busy && !res_valid) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= q_item;
      for (int p = 0; p < NPH; p++) begin
        st[p].rem  <= q_item.ph[p].mag;
        st[p].quot <= '0;
      end
    end else if (busy && !res_valid) begin
      for (int p = 0; p < NPH; p++) st[p] <= st_next[p];
    end
  end

endmodule

/* rtl/dvc_arith.sv */
// Back-end arithmetic pipeline: phase compensation with common mode removed,
// division by 3*2^31 with rounding, Clarke recombination, output register.
// Depends on dvc_pkg.
module dvc_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sign_invert,
  input  logic                          res_valid,
  input  dvc_pkg::div_res_t             res,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [dvc_pkg::DW-1:0] alpha_out,
  output logic signed [dvc_pkg::DW-1:0] beta_out,
  output logic signed [dvc_pkg::DW-1:0] comp_u,
  output logic signed [dvc_pkg::DW-1:0] comp_v,
  output logic signed [dvc_pkg::DW-1:0] comp_w,
  output logic                          comp_active
);
  import dvc_pkg::*;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW+1:0] x);
    logic signed [DW+1:0] hi;
    logic signed [DW+1:0] lo;
    hi = (DW+2)'({1'b0, {(DW-1){1'b1}}});
    lo = ~hi;
    if (x > hi)      return hi[DW-1:0];
    else if (x < lo) return lo[DW-1:0];
    else             return x[DW-1:0];
  endfunction

  logic adv;

  // stage 1 combinational
  logic [SQ-1:0]         quot_m [NPH];
  logic signed [SW-1:0]  s_val  [NPH];
  logic signed [TSW-1:0] s_sum;
  logic signed [TSW-1:0] t_val  [NPH];
  // stage 3 / 4 / 5 / 6 combinational
  logic [YW+RW-1:0]      rp     [NPH];
  logic signed [DW+1:0]  cq     [NPH];
  logic signed [DW:0]    d_val;
  logic [DW:0]           d_abs;
  logic [DW:0]           bt_mag;
  logic signed [DW+1:0]  bt;

  logic                  v1, v2, v3, v4, v5;
  logic                  byp1, byp2, byp3, byp4, byp5;
  logic signed [DW-1:0]  a1, a2, a3, a4, a5;
  logic signed [DW-1:0]  b1, b2, b3, b4, b5;
  logic [MW-1:0]         m1;
  logic [NPH-1:0]        tneg1, tneg2, tneg3;
  logic [TW-1:0]         tabs1 [NPH];
  logic [PW-1:0]         p2    [NPH];
  logic [QW-1:0]         q3    [NPH];
  logic signed [DW-1:0]  c4    [NPH];
  logic signed [DW-1:0]  c5    [NPH];
  logic signed [DW-1:0]  asum5;
  logic                  dneg5;
  logic [2*DW:0]         bprod5;

  assign adv  = !out_valid || !out_stall;
  assign take = adv;

  always_comb begin
    s_sum = '0;
    for (int p = 0; p < NPH; p++) begin
      quot_m[p] = (res.item.ph[p].mag == '0) ? '0 : res.quot[p];
      if (res.item.ph[p].sat)
        s_val[p] = res.item.ph[p].neg ? -SIGN_ONE : SIGN_ONE;
      else if (res.item.ph[p].neg)
        s_val[p] = -$signed({2'b00, quot_m[p]});
      else
        s_val[p] = $signed({2'b00, quot_m[p]});
      s_sum = s_sum + TSW'(s_val[p]);
    end
    for (int p = 0; p < NPH; p++) begin
      t_val[p] = (TSW'(s_val[p]) <<< 1) + TSW'(s_val[p]) - s_sum;
      rp[p]    = (YW+RW)'(p2[p][PW-1 -: YW]) * (YW+RW)'(RECIP3);
      cq[p]    = (tneg3[p] ^ sign_invert) ? -$signed({1'b0, q3[p]})
                                          : $signed({1'b0, q3[p]});
    end
    d_val  = (DW+1)'(c4[1]) - (DW+1)'(c4[2]);
    d_abs  = d_val[DW] ? (DW+1)'(-d_val) : (DW+1)'(d_val);
    bt_mag = bprod5[2*DW -: (DW+1)];
    bt     = dneg5 ? -$signed({1'b0, bt_mag}) : $signed({1'b0, bt_mag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= res_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // s1: signs and common-mode removed direction
      byp1 <= res.item.bypass;
      a1   <= res.item.alpha;
      b1   <= res.item.beta;
      m1   <= res.item.mag_v;
      for (int p = 0; p < NPH; p++) begin
        tneg1[p] <= t_val[p][TSW-1];
        tabs1[p] <= t_val[p][TSW-1] ? TW'(-t_val[p]) : TW'(t_val[p]);
      end
      // s2: magnitude times direction, plus half divisor
      byp2  <= byp1;
      a2    <= a1;
      b2    <= b1;
      tneg2 <= tneg1;
      for (int p = 0; p < NPH; p++) p2[p] <= PW'(m1) * PW'(tabs1[p]) + COMP_RND;
      // s3: divide by three through reciprocal
      byp3  <= byp2;
      a3    <= a2;
      b3    <= b2;
      tneg3 <= tneg2;
      for (int p = 0; p < NPH; p++) q3[p] <= rp[p][RECIP_SH +: QW];
      // s4: apply direction and saturate phase values
      byp4 <= byp3;
      a4   <= a3;
      b4   <= b3;
      for (int p = 0; p < NPH; p++) c4[p] <= sat_dw(cq[p]);
      // s5: alpha sum, beta difference times 1/sqrt(3)
      byp5   <= byp4;
      b5     <= b4;
      a5     <= a4;
      asum5  <= sat_dw((DW+2)'(a4) + (DW+2)'(c4[0]));
      dneg5  <= d_val[DW];
      bprod5 <= (2*DW+1)'(d_abs) * (2*DW+1)'(RT3_RECIP) + (2*DW+1)'(32768);
      for (int p = 0; p < NPH; p++) c5[p] <= c4[p];
      // output register
      if (byp5) begin
        alpha_out   <= a5;
        beta_out    <= b5;
        comp_u      <= '0;
        comp_v      <= '0;
        comp_w      <= '0;
        comp_active <= 1'b0;
      end else begin
        alpha_out   <= asum5;
        beta_out    <= sat_dw((DW+2)'(b5) + bt);
        comp_u      <= c5[0];
        comp_v      <= c5[1];
        comp_w      <= c5[2];
        comp_active <= 1'b1;
      end
    end
  end

endmodule

/* rtl/deadtime_voltage_compensator.sv */
// Three-phase dead-time voltage compensator: accepts one sample (bus voltage,
// phase currents, alpha/beta command) per request and returns the compensated
// alpha/beta command with the per-phase compensation voltages. Throughput is
// limited by the smooth-sign divider, which produces 5 quotient bits per cycle
// for 15 bits and works on one sample at a time: it takes the next sample from
// the queue only when the arithmetic pipeline takes its result. A sample flows
// through a 4-entry queue, the divider and a 6-register arithmetic pipeline.
// While results wait at the output the queue keeps taking samples until it
// holds four. Configuration registers are written through the cfg port; the
// user must write them only while idle, which the block itself leaves unenforced.
module deadtime_voltage_compensator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dvc_pkg::VW-1:0]        bus_voltage,
  input  logic signed [dvc_pkg::DW-1:0] current_u,
  input  logic signed [dvc_pkg::DW-1:0] current_v,
  input  logic signed [dvc_pkg::DW-1:0] current_w,
  input  logic signed [dvc_pkg::DW-1:0] alpha_in,
  input  logic signed [dvc_pkg::DW-1:0] beta_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [dvc_pkg::DW-1:0] alpha_out,
  output logic signed [dvc_pkg::DW-1:0] beta_out,
  output logic signed [dvc_pkg::DW-1:0] comp_u,
  output logic signed [dvc_pkg::DW-1:0] comp_v,
  output logic signed [dvc_pkg::DW-1:0] comp_w,
  output logic                          comp_active,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dvc_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [dvc_pkg::CFG_DW-1:0]    cfg_data
);
  import dvc_pkg::*;

  cfg_t      cfg;
  item_t     f_item;
  item_t     q_item;
  div_res_t  d_res;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_nonempty;
  logic      d_valid;
  logic      take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_bus_voltage   <= '0;
      cfg.gain_base         <= '0;
      cfg.gain_max          <= '1;
      cfg.current_threshold <= '0;
      cfg.sign_invert       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_BUS:   cfg.min_bus_voltage   <= cfg_data[VW-1:0];
        REG_GAIN_BASE: cfg.gain_base         <= cfg_data[GW-1:0];
        REG_GAIN_MAX:  cfg.gain_max          <= cfg_data[GW-1:0];
        REG_THRESHOLD: cfg.current_threshold <= cfg_data[VW-1:0];
        REG_SIGN_INV:  cfg.sign_invert       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dvc_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .bus_voltage (bus_voltage),
    .current_u   (current_u),
    .current_v   (current_v),
    .current_w   (current_w),
    .alpha_in    (alpha_in),
    .beta_in     (beta_in),
    .cfg         (cfg),
    .q_full      (q_full),
    .push        (push),
    .item        (f_item)
  );

  dvc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (f_item),
    .pop      (pop),
    .nonempty (q_nonempty),
    .full     (q_full),
    .dout     (q_item)
  );

  dvc_sign_div u_div (
    .clk        (clk),
    .rst        (rst),
    .threshold  (cfg.current_threshold),
    .q_nonempty (q_nonempty),
    .q_item     (q_item),
    .pop        (pop),
    .take       (take),
    .res_valid  (d_valid),
    .res        (d_res)
  );

  dvc_arith u_arith (
    .clk         (clk),
    .rst         (rst),
    .sign_invert (cfg.sign_invert),
    .res_valid   (d_valid),
    .res         (d_res),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .alpha_out   (alpha_out),
    .beta_out    (beta_out),
    .comp_u      (comp_u),
    .comp_v      (comp_v),
    .comp_w      (comp_w),
    .comp_active (comp_active)
  );

endmodule

/* rtl/dvc_checker.sv */
// Port-level checks for the dead-time compensator, bound to the top level.
// Depends on dvc_pkg and the top level's ports.
module dvc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [dvc_pkg::DW-1:0] alpha_out,
  input logic signed [dvc_pkg::DW-1:0] beta_out,
  input logic signed [dvc_pkg::DW-1:0] comp_u,
  input logic signed [dvc_pkg::DW-1:0] comp_v,
  input logic signed [dvc_pkg::DW-1:0] comp_w,
  input logic                          comp_active
);

  logic [4:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(alpha_out) && $stable(beta_out)
      && $stable(comp_u) && $stable(comp_v) && $stable(comp_w))
    else $error("stalled result changed");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != '0)
    else $error("result delivered with no request outstanding");

  a_bypass_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !comp_active |-> comp_u == '0 && comp_v == '0 && comp_w == '0)
    else $error("bypassed result carries compensation");

endmodule

bind deadtime_voltage_compensator dvc_checker u_dvc_checker (.*);
